/* hw/rtl/lzwc_pkg.sv */
// ----------------------------------------------------------------------------
// lzwc_pkg
// Shared types, constants and the dictionary hash of the LZW compressor.
// ----------------------------------------------------------------------------
`default_nettype none

package lzwc_pkg;

  localparam int CodeBits  = 16;
  localparam int CodeW     = 16;
  localparam int TableAw   = 16;
  localparam int EpochW    = 8;

  localparam logic [CodeW-1:0]  FirstLearned = CodeW'(258);
  localparam logic [CodeW-1:0]  EndCode      = CodeW'(256);
  localparam logic [CodeW-1:0]  ClearCode    = CodeW'(257);
  localparam logic [CodeW-1:0]  ResetCode    = CodeW'((32'd1 << CodeBits) - 32'd1);
  localparam logic [EpochW-1:0] EpochMax     = '1;

  typedef enum logic {
    KIND_DATA  = 1'b0,
    KIND_FLUSH = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [EpochW-1:0] epoch;
    logic [CodeW-1:0]  prefix;
    logic [7:0]        data_byte;
    logic [CodeW-1:0]  code;
  } slot_t;

  function automatic logic [TableAw-1:0] hash_pair(input logic [CodeW-1:0] prefix,
                                                   input logic [7:0] b);
    logic [15:0] p;
    logic [15:0] m;
    p = 16'(prefix);
    m = 16'(b) * 16'h009D;
    return TableAw'({p[7:0], 8'h00} ^ {8'h00, p[15:8]} ^ m);
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/lzwc_front.sv */
// ----------------------------------------------------------------------------
// lzwc_front
// Accepts input requests, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none

module lzwc_front import lzwc_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  wire logic [7:0] s_axis_tdata_i,
  input  wire logic       s_axis_tuser_i,
  output logic            item_valid_o,
  output item_t           item_o,
  input  wire logic       item_pop_i
);

  item_t      buf_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push;
  item_t      in_item;

  assign s_axis_tready_o = (cnt_q != 2'd2);
  assign push            = s_axis_tvalid_i && s_axis_tready_o;
  assign item_valid_o    = (cnt_q != 2'd0);
  assign item_o          = buf_q[rd_q];

  always_comb begin
    in_item.kind      = s_axis_tuser_i ? KIND_FLUSH : KIND_DATA;
    in_item.data_byte = s_axis_tdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (item_pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push) - 2'(item_pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) buf_q[wr_q] <= in_item;
  end

endmodule

`default_nettype wire

/* hw/rtl/lzwc_back.sv */
// ----------------------------------------------------------------------------
// lzwc_back
// Match tracking, hashed dictionary with linear probing, and code output.
// ----------------------------------------------------------------------------
`default_nettype none

module lzwc_back import lzwc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        item_valid_i,
  input  item_t            item_i,
  output logic             item_pop_o,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [CodeW-1:0] m_axis_tdata_o,
  output logic             m_axis_tlast_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CMP   = 3'd1;
  localparam logic [2:0] S_EMITA = 3'd2;
  localparam logic [2:0] S_EMITB = 3'd3;
  localparam logic [2:0] S_CLEAR = 3'd4;

  logic [2:0]         state_q, state_d;
  logic [CodeW-1:0]   cur_q, cur_d, next_q, next_d, code_a_q, code_a_d, code_b_q, code_b_d;
  logic               have_q, have_d, last_a_q, last_a_d, two_q, two_d;
  logic               pend_q, pend_d;
  logic [EpochW-1:0]  epoch_q, epoch_d;
  logic [TableAw-1:0] addr_q, addr_d, clr_q, clr_d;
  logic [7:0]         byte_q, byte_d;
  logic               mv_q, mv_d, ml_q, ml_d;
  logic [CodeW-1:0]   mc_q, mc_d;

  slot_t              mem [2**TableAw];
  slot_t              rdata_q, wdata;
  logic               re, we;
  logic [TableAw-1:0] raddr, waddr;

  logic               slot_live, slot_hit, out_free;
  logic [CodeW-1:0]   nxt;

  assign slot_live = (rdata_q.epoch == epoch_q);
  assign slot_hit  = slot_live && (rdata_q.prefix == cur_q) && (rdata_q.data_byte == byte_q);
  assign out_free  = !mv_q || m_axis_tready_i;
  assign nxt       = next_q + CodeW'(1);

  always_comb begin
    state_d = state_q; cur_d = cur_q; next_d = next_q; have_d = have_q;
    code_a_d = code_a_q; code_b_d = code_b_q; last_a_d = last_a_q; two_d = two_q;
    pend_d = pend_q; epoch_d = epoch_q; addr_d = addr_q; clr_d = clr_q; byte_d = byte_q;
    mv_d = mv_q && !m_axis_tready_i; mc_d = mc_q; ml_d = ml_q;
    item_pop_o = 1'b0;
    re = 1'b0; raddr = addr_q;
    we = 1'b0; waddr = addr_q; wdata = '0;

    unique case (state_q)
      S_IDLE: begin
        if (item_valid_i) begin
          item_pop_o = 1'b1;
          if (item_i.kind == KIND_FLUSH) begin
            if (have_q) begin
              code_a_d = cur_q; last_a_d = 1'b0; two_d = 1'b1; code_b_d = EndCode;
            end else begin
              code_a_d = EndCode; last_a_d = 1'b1; two_d = 1'b0;
            end
            have_d = 1'b0; cur_d = '0; next_d = FirstLearned;
            if (epoch_q == EpochMax) pend_d = 1'b1;
            else epoch_d = epoch_q + EpochW'(1);
            state_d = S_EMITA;
          end else if (!have_q) begin
            cur_d = CodeW'(item_i.data_byte); have_d = 1'b1;
          end else begin
            byte_d  = item_i.data_byte;
            addr_d  = hash_pair(cur_q, item_i.data_byte);
            re      = 1'b1; raddr = addr_d;
            state_d = S_CMP;
          end
        end
      end
      S_CMP: begin
        if (slot_hit) begin
          cur_d = rdata_q.code; state_d = S_IDLE;
        end else if (!slot_live) begin
          we = 1'b1;
          wdata.epoch = epoch_q; wdata.prefix = cur_q;
          wdata.data_byte = byte_q; wdata.code = next_q;
          code_a_d = cur_q;
          if (nxt == ResetCode) begin
            last_a_d = 1'b0; two_d = 1'b1; code_b_d = ClearCode; next_d = FirstLearned;
            if (epoch_q == EpochMax) pend_d = 1'b1;
            else epoch_d = epoch_q + EpochW'(1);
          end else begin
            last_a_d = 1'b1; two_d = 1'b0; next_d = nxt;
          end
          cur_d = CodeW'(byte_q);
          state_d = S_EMITA;
        end else begin
          addr_d = addr_q + TableAw'(1);
          re = 1'b1; raddr = addr_d;
        end
      end
      S_EMITA: begin
        if (out_free) begin
          mv_d = 1'b1; mc_d = code_a_q; ml_d = last_a_q;
          if (two_q) state_d = S_EMITB;
          else state_d = pend_q ? S_CLEAR : S_IDLE;
        end
      end
      S_EMITB: begin
        if (out_free) begin
          mv_d = 1'b1; mc_d = code_b_q; ml_d = 1'b1;
          state_d = pend_q ? S_CLEAR : S_IDLE;
        end
      end
      S_CLEAR: begin
        we = 1'b1; waddr = clr_q; wdata = '0;
        clr_d = clr_q + TableAw'(1);
        if (clr_q == '1) begin
          epoch_d = EpochW'(1); pend_d = 1'b0; state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      cur_q   <= '0;
      have_q  <= 1'b0;
      next_q  <= FirstLearned;
      epoch_q <= EpochMax;
      pend_q  <= 1'b1;
      clr_q   <= '0;
      mv_q    <= 1'b0;
      two_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cur_q   <= cur_d;
      have_q  <= have_d;
      next_q  <= next_d;
      epoch_q <= epoch_d;
      pend_q  <= pend_d;
      clr_q   <= clr_d;
      mv_q    <= mv_d;
      two_q   <= two_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_a_q <= code_a_d;
    code_b_q <= code_b_d;
    last_a_q <= last_a_d;
    addr_q   <= addr_d;
    byte_q   <= byte_d;
    mc_q     <= mc_d;
    ml_q     <= ml_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_q <= mem[raddr];
  end

  assign m_axis_tvalid_o = mv_q;
  assign m_axis_tdata_o  = mc_q;
  assign m_axis_tlast_o  = ml_q;

endmodule

`default_nettype wire

/* hw/rtl/lzw_compressor_16bit.sv */
// ----------------------------------------------------------------------------
// lzw_compressor_16bit
// LZW compressor with fixed 16-bit codes.
// ----------------------------------------------------------------------------
// Input stream: one request per byte (tuser 0) or end of stream (tuser 1).
// Output stream: 16-bit codes; tlast marks the final code of one request.
// 256 ends a stream, 257 tells the decoder the dictionary was reset.
// A byte that only extends the match takes a hash read and a compare; each
// extra probe of the hashed dictionary (one read port, linear probing) adds
// a compare. One or two codes are then handed over, also at end of stream.
// A two-entry input queue decouples acceptance from dictionary work.
// After reset, and after every 255 dictionary clears (end of stream or
// reset marker), a sweep over all 65536 slots clears the dictionary; no
// requests are taken meanwhile beyond the two queue entries. A stalled
// receiver holds the output register and then stops the dictionary
// engine; the input queue fills and tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module lzw_compressor_16bit import lzwc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  wire logic        s_axis_tuser_i,   // [0] command
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [CodeW-1:0] m_axis_tdata_o,   // [15:0] out_code
  output logic             m_axis_tlast_o
);

  logic  item_valid, item_pop;
  item_t item;

  lzwc_front u_front (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i, .s_axis_tuser_i,
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  lzwc_back u_back (
    .clk_i, .rst_ni,
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o, .m_axis_tlast_o
  );

endmodule

`default_nettype wire

/* hw/rtl/lzwc_checker.sv */
// ----------------------------------------------------------------------------
// lzwc_checker
// Port-level checks of the LZW compressor, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lzwc_checker import lzwc_pkg::*; (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             m_axis_tvalid_o,
  input wire logic             m_axis_tready_i,
  input wire logic [CodeW-1:0] m_axis_tdata_o,
  input wire logic             m_axis_tlast_o
);

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("output request dropped while stalled");

  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("output code changed while stalled");

  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o == EndCode |-> m_axis_tlast_o)
    else $error("end code without tlast");

  a_clear_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o == ClearCode |-> m_axis_tlast_o)
    else $error("clear code without tlast");

endmodule

bind lzw_compressor_16bit lzwc_checker u_lzwc_checker (
  .clk_i, .rst_ni, .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o, .m_axis_tlast_o
);

`default_nettype wire
